// ===== rtl/nce_pkg.sv =====
// Package for the numeric character reference encoder.
// Holds widths, ASCII codes, the conversion word type and one double-dabble step.
// Depends on nothing.
package nce_pkg;

    localparam int CODE_W          = 16;
    localparam int BCD_DIGITS      = 5;
    localparam int BCD_W           = 4 * BCD_DIGITS;
    localparam int STAGES          = 4;
    localparam int STEPS_PER_STAGE = CODE_W / STAGES;

    localparam logic [CODE_W-1:0] PASS_LIMIT = 16'd255;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_ZERO = 8'h30;

    // One character on its way through the binary to decimal conversion.
    typedef struct packed {
        logic              pass;
        logic [7:0]        raw_byte;
        logic [BCD_W-1:0]  bcd;
        logic [CODE_W-1:0] bin;
    } dd_word_t;

    // One shift-and-add-3 step: add 3 to every decimal digit of 5 or more, then shift one bit in.
    function automatic dd_word_t dd_step(input dd_word_t w);
        dd_word_t                   r;
        logic [BCD_W+CODE_W-1:0]    sh;
        r = w;
        for (int d = 0; d < BCD_DIGITS; d++)
        begin
            if (r.bcd[4*d +: 4] >= 4'd5)
            begin
                r.bcd[4*d +: 4] = r.bcd[4*d +: 4] + 4'd3;
            end
        end
        sh    = {r.bcd, r.bin} << 1;
        r.bcd = sh[BCD_W+CODE_W-1:CODE_W];
        r.bin = sh[CODE_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/numeric_char_reference_encoder.sv =====
// Numeric character reference encoder: four conversion stages and a byte serializer.
// Uses nce_pkg for widths, ASCII codes and the double-dabble step.
//
// Path: each character passes every conversion stage register, then the serializer.
// Throughput: one word per cycle for codes up to 255 with m_tready high; a larger code holds
// the serializer for its run (&, #, 3 to 5 digits, ;), and the pipeline stalls behind it.
// Reset: rst_n clears all valid bits asynchronously; no payload register is reset.
module numeric_char_reference_encoder
    import nce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] code_unit
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast    // last_of_run
);

    // Conversion pipeline registers.
    logic [STAGES-1:0] vld_reg;
    dd_word_t          st_reg  [STAGES];
    dd_word_t          st_next [STAGES];
    logic [STAGES:0]   stg_ready;
    logic [STAGES-1:0] in_vld;

    // Serializer registers.
    logic              ser_valid_reg;
    logic              ser_pass_reg;
    logic [7:0]        ser_raw_reg;
    logic [BCD_W-1:0]  ser_digits_reg;
    logic [2:0]        ser_nd_reg;
    logic [2:0]        ser_idx_reg;
    logic [2:0]        ser_nd_next;
    logic              ser_last;
    logic              ser_ready;
    logic [2:0]        dig_sel;
    logic [3:0]        dig_val;

    // Ready chain: a stage takes a new word when it is empty or its word moves on.
    always_comb
    begin
        stg_ready[STAGES] = ser_ready;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            stg_ready[k] = !vld_reg[k] || stg_ready[k+1];
        end
    end

    assign s_tready = stg_ready[0];

    // Each stage runs a quarter of the shift-and-add-3 steps.
    always_comb
    begin
        dd_word_t w;
        for (int k = 0; k < STAGES; k++)
        begin
            if (k == 0)
            begin
                w.pass     = (s_tdata <= PASS_LIMIT);
                w.raw_byte = s_tdata[7:0];
                w.bcd      = '0;
                w.bin      = s_tdata;
                in_vld[k]  = s_tvalid;
            end
            else
            begin
                w         = st_reg[k-1];
                in_vld[k] = vld_reg[k-1];
            end
            for (int s = 0; s < STEPS_PER_STAGE; s++)
            begin
                w = dd_step(w);
            end
            st_next[k] = w;
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (stg_ready[k])
                begin
                    vld_reg[k] <= in_vld[k];
                end
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            if (stg_ready[k] && in_vld[k])
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    // Digit count of the finished conversion; a reference always has at least three.
    always_comb
    begin
        if (st_reg[STAGES-1].bcd[19:16] != 4'd0)
        begin
            ser_nd_next = 3'd5;
        end
        else if (st_reg[STAGES-1].bcd[15:12] != 4'd0)
        begin
            ser_nd_next = 3'd4;
        end
        else
        begin
            ser_nd_next = 3'd3;
        end
    end

    // The serializer frees up once the last byte of its run is taken.
    assign ser_last  = ser_pass_reg || (ser_idx_reg == ser_nd_reg + 3'd2);
    assign ser_ready = !ser_valid_reg || (m_tready && ser_last);

    // Serializer control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            ser_idx_reg   <= '0;
        end
        else if (ser_ready)
        begin
            ser_valid_reg <= vld_reg[STAGES-1];
            ser_idx_reg   <= '0;
        end
        else if (m_tready)
        begin
            ser_idx_reg <= ser_idx_reg + 3'd1;
        end
    end

    // Serializer payload.
    always_ff @(posedge clk)
    begin
        if (ser_ready && vld_reg[STAGES-1])
        begin
            ser_pass_reg   <= st_reg[STAGES-1].pass;
            ser_raw_reg    <= st_reg[STAGES-1].raw_byte;
            ser_digits_reg <= st_reg[STAGES-1].bcd;
            ser_nd_reg     <= ser_nd_next;
        end
    end

    // Byte selection: digits go out most significant first after '&' and '#'.
    assign dig_sel = ser_nd_reg + 3'd1 - ser_idx_reg;

    always_comb
    begin
        unique case (dig_sel)
            3'd0:    dig_val = ser_digits_reg[3:0];
            3'd1:    dig_val = ser_digits_reg[7:4];
            3'd2:    dig_val = ser_digits_reg[11:8];
            3'd3:    dig_val = ser_digits_reg[15:12];
            3'd4:    dig_val = ser_digits_reg[19:16];
            default: dig_val = 4'd0;
        endcase
    end

    always_comb
    begin
        if (ser_pass_reg)
        begin
            m_tdata = ser_raw_reg;
        end
        else if (ser_idx_reg == 3'd0)
        begin
            m_tdata = CH_AMP;
        end
        else if (ser_idx_reg == 3'd1)
        begin
            m_tdata = CH_HASH;
        end
        else if (ser_last)
        begin
            m_tdata = CH_SEMI;
        end
        else
        begin
            m_tdata = CH_ZERO | {4'h0, dig_val};
        end
    end

    assign m_tvalid = ser_valid_reg;
    assign m_tlast  = ser_valid_reg && ser_last;

`ifndef SYNTHESIS
    // A pass-through character is always a run of one word.
    a_pass_single: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && ser_pass_reg) |-> m_tlast)
        else $error("pass-through word not marked last");

    // A reference run ends with the semicolon.
    a_ref_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast && !ser_pass_reg) |-> (m_tdata == CH_SEMI))
        else $error("reference run does not end with semicolon");

    // The byte position never runs past the end of a reference.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ser_valid_reg && !ser_pass_reg) |-> (ser_idx_reg <= ser_nd_reg + 3'd2))
        else $error("serializer position out of range");

    // After a non-final word is taken the run continues with the next position.
    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && ser_idx_reg == $past(ser_idx_reg) + 3'd1))
        else $error("serializer position did not advance");
`endif

endmodule

// ===== test/numeric_char_reference_encoder_test.sv =====
// Self-checking testbench for numeric_char_reference_encoder: a directed table, then random codes.
// Every output word is checked against typed table bytes or a local encoder of HTML numeric character references.
// Depends on nce_pkg and rtl/numeric_char_reference_encoder.sv.
module numeric_char_reference_encoder_test
    import nce_pkg::*;
();

    // One output word: a byte of the encoded text and its end-of-run mark.
    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_run;
    } enc_word_t;

    // One row of the directed table. A nonzero n_typed means the expected bytes are
    // typed in, first byte in the highest used bits of typed; zero means use the encoder.
    typedef struct packed {
        logic [15:0] code;
        logic [3:0]  n_typed;
        logic [63:0] typed;
    } char_row_t;

    localparam int N_DIRECTED   = 20;
    localparam int N_RANDOM     = 160;
    localparam int IDLE_PERCENT = 18;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 16;

    localparam char_row_t CHAR_ROWS [N_DIRECTED] = '{
        '{16'd0,     4'd1, 64'h00},
        '{16'd1,     4'd0, 64'h0},
        '{16'd127,   4'd0, 64'h0},
        '{16'd128,   4'd0, 64'h0},
        '{16'h0055,  4'd0, 64'h0},
        '{16'h00AA,  4'd0, 64'h0},
        '{16'd254,   4'd0, 64'h0},
        '{16'd255,   4'd1, 64'hFF},
        '{16'd256,   4'd6, "&#256;"},
        '{16'd257,   4'd0, 64'h0},
        '{16'd999,   4'd0, 64'h0},
        '{16'd1000,  4'd7, "&#1000;"},
        '{16'd9999,  4'd7, "&#9999;"},
        '{16'd10000, 4'd8, "&#10000;"},
        '{16'h5555,  4'd0, 64'h0},
        '{16'hAAAA,  4'd0, 64'h0},
        '{16'h8000,  4'd0, 64'h0},
        '{16'h7FFF,  4'd0, 64'h0},
        '{16'd12345, 4'd0, 64'h0},
        '{16'd65535, 4'd8, "&#65535;"}
    };

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    enc_word_t   encoded_q[$];
    int          error_count = 0;
    int          words_checked = 0;
    int          chars_sent = 0;
    int          refs_sent = 0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;

    numeric_char_reference_encoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Encode one character code the way the block should and queue the resulting words.
    function automatic void encode_char(input logic [15:0] code);
        logic [7:0] digit_chars [5];
        int         n_digits;
        int         value;
        n_digits = 0;
        value    = code;
        if (code <= PASS_LIMIT)
        begin
            encoded_q.push_back('{code[7:0], 1'b1});
        end
        else
        begin
            while (value != 0)
            begin
                digit_chars[n_digits] = CH_ZERO + 8'(value % 10);
                value                 = value / 10;
                n_digits++;
            end
            encoded_q.push_back('{CH_AMP, 1'b0});
            encoded_q.push_back('{CH_HASH, 1'b0});
            for (int i = n_digits - 1; i >= 0; i--)
            begin
                encoded_q.push_back('{digit_chars[i], 1'b0});
            end
            encoded_q.push_back('{CH_SEMI, 1'b1});
        end
    endfunction

    // Random code, weighted so that every digit count and the pass-through range show up.
    function automatic logic [15:0] pick_code();
        logic [15:0] code;
        case ($urandom_range(0, 4))
            0:       code = 16'($urandom_range(0, 255));
            1:       code = 16'($urandom_range(256, 999));
            2:       code = 16'($urandom_range(1000, 9999));
            3:       code = 16'($urandom_range(10000, 65535));
            default: code = 16'($urandom);
        endcase
        return code;
    endfunction

    // Offer one character and wait for the block to take it, then queue what it should produce.
    task automatic send_char(input logic [15:0] code, input logic [3:0] n_typed,
                             input logic [63:0] typed);
        while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        chars_sent++;
        if (code > PASS_LIMIT)
        begin
            refs_sent++;
        end
        if (n_typed == 0)
        begin
            encode_char(code);
        end
        else
        begin
            for (int i = 0; i < n_typed; i++)
            begin
                encoded_q.push_back('{typed[8*(n_typed-1-i) +: 8], 1'(i == n_typed - 1)});
            end
        end
    endtask

    // Receiver back-pressure: random stalls, a quiet stretch, and one long hold-off.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end
        else if (quiet)
        begin
            m_tready <= 1'b1;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Compare every accepted output word with the oldest queued one.
    always @(posedge clk)
    begin
        enc_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (encoded_q.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected word: expected none, got byte %02h last %0b",
                         $time, m_tdata, m_tlast);
            end
            else
            begin
                want = encoded_q.pop_front();
                words_checked++;
                if (m_tdata !== want.out_char)
                begin
                    error_count++;
                    $display("%0t: out_byte mismatch: expected %02h, got %02h",
                             $time, want.out_char, m_tdata);
                end
                if (m_tlast !== want.last_of_run)
                begin
                    error_count++;
                    $display("%0t: last_of_run mismatch: expected %0b, got %0b",
                             $time, want.last_of_run, m_tlast);
                end
            end
        end
    end

    // Stimulus: reset, the directed table, then random codes with phases of different pressure.
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_char(CHAR_ROWS[i].code, CHAR_ROWS[i].n_typed, CHAR_ROWS[i].typed);
        end

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == 40)
            begin
                quiet = 1'b1;
            end
            if (i == 90)
            begin
                quiet = 1'b0;
            end
            if (i == 120)
            begin
                hold_req = 1'b1;
            end
            send_char(pick_code(), 4'd0, 64'h0);
        end
        s_tvalid <= 1'b0;

        while (encoded_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d characters (%0d as numeric references), checked %0d output words.",
                 chars_sent, refs_sent, words_checked);
        $display("Covered pass-through codes, 3 to 5 digit references and a long output stall.");
        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2000000;
        $display("Timeout with %0d output words still outstanding.", encoded_q.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/nce_pkg.sv
rtl/numeric_char_reference_encoder.sv
test/numeric_char_reference_encoder_test.sv
